>>> design/emq_pkg.sv
// Endpoint mailbox queues: shared types, sizes and codes.
// Used by emq_ctrl, the top level and the bench; depends on nothing.

package emq_pkg;

    // Sizing
    localparam int CHANNELS    = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int MEM_DEPTH   = CHANNELS * QUEUE_DEPTH;

    localparam int EP_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int ENDPOINT_W = 3;
    localparam int MSG_W      = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LISTEN = 2'd0,
        CMD_SEND   = 2'd1,
        CMD_RECV   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_ENDPOINT = 3'd1,
        ST_NOT_OPEN     = 3'd2,
        ST_FULL         = 3'd3,
        ST_EMPTY        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [ENDPOINT_W-1:0] endpoint;
        logic [MSG_W-1:0]      message;
    } req_t;

    typedef struct packed {
        logic             ok;
        status_t          status;
        logic [MSG_W-1:0] data;
    } rsp_t;

    // Decision of the endpoint table for one command
    typedef struct packed {
        status_t           status;
        logic              push;
        logic              pop;
        logic [ADDR_W-1:0] addr;
    } op_t;

endpackage

>>> design/emq_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package needed.

module emq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle while en is high
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/emq_ctrl.sv
// Endpoint table: open flags, head pointers and fill counts, plus command checks.
// Depends on emq_pkg for sizes, codes and the op_t decision struct.

module emq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  emq_pkg::req_t req,
    output emq_pkg::op_t  op
);

    logic                        open_reg  [emq_pkg::CHANNELS];
    logic [emq_pkg::SLOT_W-1:0]  head_reg  [emq_pkg::CHANNELS];
    logic [emq_pkg::COUNT_W-1:0] count_reg [emq_pkg::CHANNELS];

    logic                        bad_ep;
    logic [emq_pkg::EP_W-1:0]    ep;
    logic                        ep_open;
    logic [emq_pkg::SLOT_W-1:0]  head;
    logic [emq_pkg::COUNT_W-1:0] count;
    logic [emq_pkg::COUNT_W:0]   tail_sum;
    logic [emq_pkg::SLOT_W-1:0]  tail;
    logic [emq_pkg::SLOT_W:0]    head_inc;
    logic [emq_pkg::SLOT_W-1:0]  head_next;
    logic [emq_pkg::SLOT_W-1:0]  slot;
    logic                        do_open;

    assign bad_ep  = {1'b0, req.endpoint} >= (emq_pkg::ENDPOINT_W + 1)'(emq_pkg::CHANNELS);
    assign ep      = emq_pkg::EP_W'(req.endpoint);
    assign ep_open = open_reg[ep];
    assign head    = head_reg[ep];
    assign count   = count_reg[ep];

    // Tail slot: head + count wraps at most once
    assign tail_sum = (emq_pkg::COUNT_W + 1)'(head) + (emq_pkg::COUNT_W + 1)'(count);
    assign tail = (tail_sum >= (emq_pkg::COUNT_W + 1)'(emq_pkg::QUEUE_DEPTH))
                ? emq_pkg::SLOT_W'(tail_sum - (emq_pkg::COUNT_W + 1)'(emq_pkg::QUEUE_DEPTH))
                : emq_pkg::SLOT_W'(tail_sum);

    // Advance head with wrap
    assign head_inc  = (emq_pkg::SLOT_W + 1)'(head) + (emq_pkg::SLOT_W + 1)'(1);
    assign head_next = (head_inc == (emq_pkg::SLOT_W + 1)'(emq_pkg::QUEUE_DEPTH))
                     ? '0 : emq_pkg::SLOT_W'(head_inc);

    // Check the command in order: endpoint, open, full or empty
    always_comb
    begin
        op.status = emq_pkg::ST_BAD_ENDPOINT;
        op.push   = 1'b0;
        op.pop    = 1'b0;
        do_open   = 1'b0;
        slot      = head;
        if (!bad_ep)
        begin
            unique case (req.cmd)
                emq_pkg::CMD_LISTEN:
                begin
                    op.status = emq_pkg::ST_OK;
                    do_open   = 1'b1;
                end
                emq_pkg::CMD_SEND:
                begin
                    slot = tail;
                    if (!ep_open)
                    begin
                        op.status = emq_pkg::ST_NOT_OPEN;
                    end
                    else if (count >= emq_pkg::COUNT_W'(emq_pkg::QUEUE_DEPTH))
                    begin
                        op.status = emq_pkg::ST_FULL;
                    end
                    else
                    begin
                        op.status = emq_pkg::ST_OK;
                        op.push   = 1'b1;
                    end
                end
                emq_pkg::CMD_RECV:
                begin
                    if (!ep_open)
                    begin
                        op.status = emq_pkg::ST_NOT_OPEN;
                    end
                    else if (count == '0)
                    begin
                        op.status = emq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        op.status = emq_pkg::ST_OK;
                        op.pop    = 1'b1;
                    end
                end
                default:
                begin
                    op.status = emq_pkg::ST_BAD_ENDPOINT;
                end
            endcase
        end
        // Message store address: endpoint row plus slot
        op.addr = emq_pkg::ADDR_W'(ep) * emq_pkg::ADDR_W'(emq_pkg::QUEUE_DEPTH)
                + emq_pkg::ADDR_W'(slot);
    end

    // Update the table entry of the executing command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < emq_pkg::CHANNELS; i++)
            begin
                open_reg[i]  <= 1'b0;
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            if (do_open)
            begin
                open_reg[ep] <= 1'b1;
            end
            if (op.push)
            begin
                count_reg[ep] <= count + emq_pkg::COUNT_W'(1);
            end
            if (op.pop)
            begin
                count_reg[ep] <= count - emq_pkg::COUNT_W'(1);
                head_reg[ep]  <= head_next;
            end
        end
    end

endmodule

>>> design/endpoint_mailbox_queues_top.sv
// Endpoint mailbox queues top level: command sequencer, endpoint table, message RAM.
// Depends on emq_pkg, emq_ctrl and emq_ram.
//
//   channel   signals              direction  handshake
//   command   start, busy, req     in         taken when start && !busy
//   result    done, rsp            out        one-cycle strobe, no back-pressure
//
// Each item is checked and accesses the message RAM in the access state,
// then the registered RAM read data is returned in the result state.
// busy is high only in the access cycle; a new item is taken while the
// previous result is on the ports. Reset closes every endpoint and empties
// every queue; the message RAM is not cleared. The receiver cannot stall.

module endpoint_mailbox_queues_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  emq_pkg::req_t req,
    output logic          done,
    output emq_pkg::rsp_t rsp
);

    emq_pkg::state_t           state_reg;
    emq_pkg::state_t           state_next;
    emq_pkg::req_t             req_reg;
    emq_pkg::status_t          status_reg;
    logic                      pop_reg;
    emq_pkg::op_t              op;
    logic                      exec;
    logic                      accept;
    logic [emq_pkg::MSG_W-1:0] rdata;

    assign accept = start && !busy;

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        exec       = 1'b0;
        unique case (state_reg)
            emq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = emq_pkg::S_EXEC;
                end
            end
            emq_pkg::S_EXEC:
            begin
                busy       = 1'b1;
                exec       = 1'b1;
                state_next = emq_pkg::S_RESP;
            end
            emq_pkg::S_RESP:
            begin
                done       = 1'b1;
                state_next = start ? emq_pkg::S_EXEC : emq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = emq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    // Hold the outcome for the result cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= emq_pkg::ST_OK;
            pop_reg    <= 1'b0;
        end
        else if (exec)
        begin
            status_reg <= op.status;
            pop_reg    <= op.pop;
        end
    end

    emq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (exec),
        .req   (req_reg),
        .op    (op)
    );

    emq_ram #(
        .WIDTH (emq_pkg::MSG_W),
        .DEPTH (emq_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (exec && (op.push || op.pop)),
        .we    (op.push),
        .addr  (op.addr),
        .wdata (req_reg.message),
        .rdata (rdata)
    );

    // Drive the result
    assign rsp.ok     = (status_reg == emq_pkg::ST_OK);
    assign rsp.status = status_reg;
    assign rsp.data   = pop_reg ? rdata : '0;

    // Checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an access cycle");

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item not executed next cycle");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.data == '0))
        else $error("refused command returned data");

    a_no_store_on_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && op.status != emq_pkg::ST_OK) |-> (!op.push && !op.pop))
        else $error("refused command touched the message store");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the endpoint mailbox queues block: command items in, one result out each.
// Needs emq_pkg and endpoint_mailbox_queues_top; a small tracker class predicts every result.
`timescale 1ns / 100ps

module testbench;

    // Command code with no operation behind it
    localparam logic [emq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 625;
    localparam int CALM_TAIL    = 100;
    localparam int MAX_REPORTS  = 10;

    // Track open flags and queued words per endpoint and the results still owed
    class endpoint_queue_tracker;
        bit                        is_open [emq_pkg::CHANNELS];
        logic [emq_pkg::MSG_W-1:0] queued [emq_pkg::CHANNELS][$];
        emq_pkg::rsp_t             expected_responses [$];
        int                        failures;
        int                        checked;
        int                        status_seen [5];

        function int pending();
            return expected_responses.size();
        endfunction

        // Predict the result of one accepted command and update the endpoint state
        function void take_command(emq_pkg::req_t r);
            emq_pkg::rsp_t             want;
            emq_pkg::status_t          st;
            logic [emq_pkg::MSG_W-1:0] word;
            int                        ep;
            ep   = int'(r.endpoint);
            word = '0;
            if (ep >= emq_pkg::CHANNELS)
                st = emq_pkg::ST_BAD_ENDPOINT;
            else
            begin
                case (r.cmd)
                    emq_pkg::CMD_LISTEN:
                    begin
                        is_open[ep] = 1'b1;
                        st = emq_pkg::ST_OK;
                    end
                    emq_pkg::CMD_SEND:
                    begin
                        if (!is_open[ep])
                            st = emq_pkg::ST_NOT_OPEN;
                        else if (queued[ep].size() >= emq_pkg::QUEUE_DEPTH)
                            st = emq_pkg::ST_FULL;
                        else
                        begin
                            queued[ep].push_back(r.message);
                            st = emq_pkg::ST_OK;
                        end
                    end
                    emq_pkg::CMD_RECV:
                    begin
                        if (!is_open[ep])
                            st = emq_pkg::ST_NOT_OPEN;
                        else if (queued[ep].size() == 0)
                            st = emq_pkg::ST_EMPTY;
                        else
                        begin
                            word = queued[ep].pop_front();
                            st = emq_pkg::ST_OK;
                        end
                    end
                    default:
                        st = emq_pkg::ST_BAD_ENDPOINT;
                endcase
            end
            want.ok     = (st == emq_pkg::ST_OK);
            want.status = st;
            want.data   = word;
            expected_responses.push_back(want);
            status_seen[int'(st)]++;
        endfunction

        // Compare one result against the oldest prediction
        function void match_response(emq_pkg::rsp_t got);
            emq_pkg::rsp_t want;
            if (expected_responses.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result with nothing outstanding: ok=%0d status=%0d data=%h",
                             got.ok, got.status, got.data);
                return;
            end
            want = expected_responses.pop_front();
            checked++;
            if (got.ok !== want.ok || got.status !== want.status || got.data !== want.data)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("ERROR: result %0d mismatch at %0t", checked, $realtime);
                    $display("    ok     expected %0d got %0d", want.ok, got.ok);
                    $display("    status expected %0d got %0d", want.status, got.status);
                    $display("    data   expected %h got %h", want.data, got.data);
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    emq_pkg::req_t req;
    logic          done;
    emq_pkg::rsp_t rsp;

    endpoint_queue_tracker tracker;
    int items_sent;

    endpoint_mailbox_queues_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

    // Sample both handshakes on the edge; check results before noting new items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.match_response(rsp);
            if (start && !busy)
                tracker.take_command(req);
        end
    end

    // Present one item and hold it until the block takes it
    task automatic issue_command(input emq_pkg::req_t r);
        start <= 1'b1;
        req   <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic emq_pkg::req_t make_command(input logic [emq_pkg::CMD_W-1:0] code,
                                                   input int ep,
                                                   input logic [emq_pkg::MSG_W-1:0] msg);
        emq_pkg::req_t r;
        r.cmd      = emq_pkg::cmd_t'(code);
        r.endpoint = emq_pkg::ENDPOINT_W'(ep);
        r.message  = msg;
        return r;
    endfunction

    function automatic logic [emq_pkg::MSG_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed traffic on a focus endpoint, with some noise mixed in
    function automatic emq_pkg::req_t random_command(input int focus, input int send_pct);
        int                          ep;
        int                          roll;
        logic [emq_pkg::CMD_W-1:0]   code;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return make_command(CMD_UNUSED, $urandom_range(0, 7), random_word());
        if (roll < 10)
            return make_command(2'($urandom_range(0, 2)), $urandom_range(emq_pkg::CHANNELS, 7),
                                random_word());
        ep = ($urandom_range(0, 9) < 7) ? focus : $urandom_range(0, emq_pkg::CHANNELS - 1);
        if ($urandom_range(0, 99) < 8)
            code = emq_pkg::CMD_LISTEN;
        else if ($urandom_range(0, 99) < send_pct)
            code = emq_pkg::CMD_SEND;
        else
            code = emq_pkg::CMD_RECV;
        return make_command(code, ep, random_word());
    endfunction

    initial
    begin
        int focus;
        int send_pct;
        tracker    = new();
        items_sent = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        focus      = 0;
        send_pct   = 50;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals on closed and out-of-range endpoints, and the unused code
        issue_command(make_command(emq_pkg::CMD_RECV, 0, '0));
        issue_command(make_command(emq_pkg::CMD_SEND, 1, 64'h0123_4567_89ab_cdef));
        issue_command(make_command(emq_pkg::CMD_LISTEN, 4, '0));
        issue_command(make_command(emq_pkg::CMD_LISTEN, 7, '1));
        issue_command(make_command(CMD_UNUSED, 0, '1));
        issue_command(make_command(emq_pkg::CMD_SEND, 5, '1));
        issue_command(make_command(emq_pkg::CMD_RECV, 7, '0));
        // Open, empty receive, data extremes, listen again keeps the queue
        issue_command(make_command(emq_pkg::CMD_LISTEN, 0, '0));
        issue_command(make_command(emq_pkg::CMD_RECV, 0, '1));
        issue_command(make_command(emq_pkg::CMD_SEND, 0, '1));
        issue_command(make_command(emq_pkg::CMD_SEND, 0, '0));
        issue_command(make_command(emq_pkg::CMD_LISTEN, 0, '1));
        issue_command(make_command(emq_pkg::CMD_RECV, 0, '0));
        issue_command(make_command(emq_pkg::CMD_RECV, 0, '0));
        issue_command(make_command(emq_pkg::CMD_RECV, 0, '0));
        // Fill the last endpoint, then overflow it
        issue_command(make_command(emq_pkg::CMD_LISTEN, emq_pkg::CHANNELS - 1, '0));
        for (int i = 0; i <= emq_pkg::QUEUE_DEPTH; i++)
            issue_command(make_command(emq_pkg::CMD_SEND, emq_pkg::CHANNELS - 1, random_word()));

        // Random blocks, each leaning toward filling or draining one endpoint
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 30 == 0)
            begin
                focus = $urandom_range(0, emq_pkg::CHANNELS - 1);
                case ($urandom_range(0, 2))
                    0:       send_pct = 15;
                    1:       send_pct = 50;
                    default: send_pct = 85;
                endcase
            end
            if (i < RANDOM_ITEMS - CALM_TAIL && (i / 50) % 3 != 2 && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 17));
            issue_command(random_command(focus, send_pct));
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        for (int k = 0; k < 200 && tracker.pending() != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d commands, checked %0d results, %0d still outstanding",
                 items_sent, tracker.checked, tracker.pending());
        $display("Status mix: ok %0d, bad endpoint %0d, not open %0d, full %0d, empty %0d",
                 tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
                 tracker.status_seen[3], tracker.status_seen[4]);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
